### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### src/sdspi_pkg.sv
package sdspi_pkg;
  localparam int unsigned BlockBytes = 512;
  localparam int unsigned DrainBytes = 514;
  localparam int unsigned QDepth = 2;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_HBYTE = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;
  localparam logic [2:0] OP_RXBYTE = 3'd5;

  localparam logic [3:0] ERR_OK = 4'd0;
  localparam logic [3:0] ERR_CMD0 = 4'd1;
  localparam logic [3:0] ERR_CMD8 = 4'd2;
  localparam logic [3:0] ERR_ACMD41 = 4'd3;
  localparam logic [3:0] ERR_CMD58 = 4'd4;
  localparam logic [3:0] ERR_BLK0 = 4'd5;
  localparam logic [3:0] ERR_CMD24 = 4'd6;
  localparam logic [3:0] ERR_WRITE = 4'd7;
  localparam logic [3:0] ERR_WTIME = 4'd8;
  localparam logic [3:0] ERR_PROG = 4'd9;
  localparam logic [3:0] ERR_CMD17 = 4'd10;
  localparam logic [3:0] ERR_RTIME = 4'd11;
  localparam logic [3:0] ERR_RTOKEN = 4'd12;
  localparam logic [3:0] ERR_RANGE = 4'd13;

  localparam logic [1:0] REG_INIT_TO = 2'd0;
  localparam logic [1:0] REG_READ_TO = 2'd1;
  localparam logic [1:0] REG_WRITE_TO = 2'd2;
  localparam logic [1:0] REG_BUSY_TO = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] block_number;
    logic [8:0]  start_offset;
    logic [9:0]  byte_count;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_n;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       want_host_byte;
    logic       done_res;
    logic       success;
    logic [3:0] error_code;
    logic [1:0] card_kind;
  } res_t;
endpackage

### src/sdspi_front.sv
module sdspi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdspi_pkg::item_t    in_item_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output sdspi_pkg::item_t    q_item_o
);
  import sdspi_pkg::*;
  // two entry queue; opcodes 6 and 7 dropped here
  item_t mem_q [QDepth];
  logic wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop, keep;

  assign keep = (in_item_i.opcode <= OP_RXBYTE);
  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rp_q];

  always_comb begin
    wp_d = push ? ~wp_q : wp_q;
    rp_d = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
endmodule

### src/sdspi_back.sv
module sdspi_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  sdspi_pkg::item_t q_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sdspi_pkg::res_t  out_res_o
);
  import sdspi_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_DUMMY = 4'd1;
  localparam logic [3:0] PH_CBUSY = 4'd2;
  localparam logic [3:0] PH_FRAME = 4'd3;
  localparam logic [3:0] PH_RESP = 4'd4;
  localparam logic [3:0] PH_R7 = 4'd5;
  localparam logic [3:0] PH_OCR = 4'd6;
  localparam logic [3:0] PH_RTOKEN = 4'd7;
  localparam logic [3:0] PH_RDATA = 4'd8;
  localparam logic [3:0] PH_WTOKEN = 4'd9;
  localparam logic [3:0] PH_WWANT = 4'd10;
  localparam logic [3:0] PH_WDATA = 4'd11;
  localparam logic [3:0] PH_WCRC = 4'd12;
  localparam logic [3:0] PH_WSTAT = 4'd13;
  localparam logic [3:0] PH_WBUSY = 4'd14;
  localparam logic [3:0] PH_R2 = 4'd15;

  localparam logic [5:0] C0 = 6'd0, C8 = 6'd8, C13 = 6'd13, C17 = 6'd17;
  localparam logic [5:0] C24 = 6'd24, C41 = 6'd41, C55 = 6'd55, C58 = 6'd58;

  logic [15:0] to_init_q, to_read_q, to_write_q, to_busy_q;
  logic [3:0]  ph_q, ph_d;
  logic [9:0]  bc_q, bc_d, bc_inc;
  logic [7:0]  pc_q, pc_d;
  logic [15:0] el_q, el_d, bm_q, bm_d;
  logic [1:0]  ct_q, ct_d;
  logic [3:0]  er_q, er_d;
  logic [31:0] arg_q, arg_d, addr;
  logic [18:0] win_q, win_d;
  logic        cs_q, cs_d;
  logic [5:0]  cmd_q, cmd_d;
  logic        ov_q;
  res_t        res_q;
  logic        emit, txv, rv, want, done, ok;
  logic [7:0]  txb, rb, db;
  logic [10:0] rend;
  logic        go;

  assign q_ready_o = !ov_q || out_ready_i;
  assign go = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_res_o = res_q;
  assign db = q_item_i.data_byte;
  assign bc_inc = bc_q + 10'd1;
  assign addr = (ct_q == 2'd2) ? q_item_i.block_number : {q_item_i.block_number[22:0], 9'd0};
  // one bit wider so an oversized count cannot wrap past the range check
  assign rend = {2'b00, q_item_i.start_offset} + {1'b0, q_item_i.byte_count};

  function automatic logic [7:0] frame_b(input logic [2:0] i, input logic [5:0] c,
                                         input logic [31:0] a);
    logic [7:0] r;
    case (i)
      3'd0: r = {2'b01, c};
      3'd1: r = a[31:24];
      3'd2: r = a[23:16];
      3'd3: r = a[15:8];
      3'd4: r = a[7:0];
      default: r = (c == C0) ? 8'h95 : ((c == C8) ? 8'h87 : 8'hFF);
    endcase
    return r;
  endfunction

  always_comb begin
    ph_d = ph_q; bc_d = bc_q; pc_d = pc_q; el_d = el_q; bm_d = bm_q;
    ct_d = ct_q; er_d = er_q; arg_d = arg_q; win_d = win_q; cs_d = cs_q;
    cmd_d = cmd_q;
    emit = 1'b0; txv = 1'b0; txb = 8'h00; rv = 1'b0; rb = 8'h00;
    want = 1'b0; done = 1'b0; ok = 1'b0;
    if (go) begin
      case (q_item_i.opcode)
        OP_INIT: if (ph_q == PH_IDLE) begin
          er_d = ERR_OK; el_d = '0; cs_d = 1'b1; bc_d = '0; ph_d = PH_DUMMY;
          emit = 1'b1; txv = 1'b1; txb = 8'hFF;
        end
        OP_READ: if (ph_q == PH_IDLE) begin
          er_d = ERR_OK; emit = 1'b1;
          if (q_item_i.byte_count == 10'd0) begin
            done = 1'b1; ok = 1'b1;
          end else if (rend > 11'(BlockBytes)) begin
            er_d = ERR_RANGE; cs_d = 1'b1; done = 1'b1;
          end else begin
            win_d = {rend[9:0], q_item_i.start_offset};
            cmd_d = C17; arg_d = addr; cs_d = 1'b0; bm_d = '0; ph_d = PH_CBUSY;
            txv = 1'b1; txb = 8'hFF;
          end
        end
        OP_WRITE: if (ph_q == PH_IDLE) begin
          er_d = ERR_OK; emit = 1'b1;
          if (q_item_i.block_number == 32'd0) begin
            er_d = ERR_BLK0; cs_d = 1'b1; done = 1'b1;
          end else begin
            cmd_d = C24; arg_d = addr; cs_d = 1'b0; bm_d = '0; ph_d = PH_CBUSY;
            txv = 1'b1; txb = 8'hFF;
          end
        end
        OP_HBYTE: if (ph_q == PH_WWANT) begin
          ph_d = PH_WDATA; emit = 1'b1; txv = 1'b1; txb = db;
        end
        OP_TICK: if (ph_q != PH_IDLE) begin
          if (el_q != 16'hFFFF) el_d = el_q + 16'd1;
          if (bm_q != 16'hFFFF) bm_d = bm_q + 16'd1;
        end
        OP_RXBYTE: if (ph_q != PH_IDLE && ph_q != PH_WWANT) begin
          emit = 1'b1; txv = 1'b1; txb = 8'hFF;
          case (ph_q)
            PH_DUMMY: begin
              bc_d = bc_inc;
              if (bc_inc >= 10'd10) begin
                cmd_d = C0; arg_d = '0; cs_d = 1'b0; bm_d = '0; ph_d = PH_CBUSY;
              end
            end
            PH_CBUSY: if (!(db != 8'hFF && bm_q < to_busy_q)) begin
              ph_d = PH_FRAME; bc_d = '0; txb = frame_b(3'd0, cmd_q, arg_q);
            end
            PH_FRAME: begin
              bc_d = bc_inc;
              if (bc_inc < 10'd6) txb = frame_b(bc_inc[2:0], cmd_q, arg_q);
              else begin
                ph_d = PH_RESP; pc_d = '0;
              end
            end
            PH_RESP: begin
              if (db[7] && pc_q != 8'hFF) pc_d = pc_q + 8'd1;
              else begin
                // response handling per command
                ph_d = PH_CBUSY; cs_d = 1'b0; bm_d = '0; arg_d = '0;
                case (cmd_q)
                  C0: begin
                    if (db == 8'h01) begin
                      cmd_d = C8; arg_d = 32'h1AA;
                    end else if (el_q > to_init_q) begin
                      er_d = ERR_CMD0; txv = 1'b0; done = 1'b1;
                    end else cmd_d = C0;
                  end
                  C8: begin
                    if (db[2]) begin
                      ct_d = 2'd0; cmd_d = C55;
                    end else begin
                      ph_d = PH_R7; bc_d = '0; cs_d = cs_q; bm_d = bm_q; arg_d = arg_q;
                    end
                  end
                  C55: begin
                    cmd_d = C41; arg_d = (ct_q == 2'd1) ? 32'h40000000 : 32'd0;
                  end
                  C41: begin
                    if (db == 8'h00) begin
                      if (ct_q == 2'd1) cmd_d = C58;
                      else begin
                        txv = 1'b0; done = 1'b1; ok = 1'b1;
                      end
                    end else if (el_q > to_init_q) begin
                      er_d = ERR_ACMD41; txv = 1'b0; done = 1'b1;
                    end else cmd_d = C55;
                  end
                  C58: begin
                    if (db != 8'h00) begin
                      er_d = ERR_CMD58; txv = 1'b0; done = 1'b1;
                    end else begin
                      ph_d = PH_OCR; bc_d = '0; bm_d = bm_q; arg_d = arg_q;
                    end
                  end
                  C24: begin
                    bm_d = bm_q; arg_d = arg_q;
                    if (db != 8'h00) begin
                      er_d = ERR_CMD24; txv = 1'b0; done = 1'b1;
                    end else begin
                      ph_d = PH_WTOKEN; txb = 8'hFE;
                    end
                  end
                  C13: begin
                    bm_d = bm_q; arg_d = arg_q;
                    if (db != 8'h00) begin
                      er_d = ERR_PROG; txv = 1'b0; done = 1'b1;
                    end else ph_d = PH_R2;
                  end
                  default: begin
                    bm_d = bm_q; arg_d = arg_q;
                    if (db != 8'h00) begin
                      er_d = ERR_CMD17; txv = 1'b0; done = 1'b1;
                    end else begin
                      ph_d = PH_RTOKEN; el_d = '0;
                    end
                  end
                endcase
                if (done) begin
                  ph_d = PH_IDLE; cs_d = 1'b1; bm_d = bm_q; arg_d = arg_q;
                end
              end
            end
            PH_R7: begin
              bc_d = bc_inc;
              if (bc_inc >= 10'd4) begin
                if (db != 8'hAA) begin
                  er_d = ERR_CMD8; txv = 1'b0; done = 1'b1; ph_d = PH_IDLE; cs_d = 1'b1;
                end else begin
                  ct_d = 2'd1; cmd_d = C55; arg_d = '0; cs_d = 1'b0; bm_d = '0;
                  ph_d = PH_CBUSY;
                end
              end
            end
            PH_OCR: begin
              if (bc_q == 10'd0 && db[7:6] == 2'b11) ct_d = 2'd2;
              bc_d = bc_inc;
              if (bc_inc >= 10'd4) begin
                txv = 1'b0; done = 1'b1; ok = 1'b1; ph_d = PH_IDLE; cs_d = 1'b1;
              end
            end
            PH_RTOKEN: begin
              if (db == 8'hFF) begin
                if (el_q > to_read_q) begin
                  er_d = ERR_RTIME; txv = 1'b0; done = 1'b1; ph_d = PH_IDLE; cs_d = 1'b1;
                end
              end else if (db != 8'hFE) begin
                er_d = ERR_RTOKEN; txv = 1'b0; done = 1'b1; ph_d = PH_IDLE; cs_d = 1'b1;
              end else begin
                ph_d = PH_RDATA; bc_d = '0;
              end
            end
            PH_RDATA: begin
              rv = (bc_q >= {1'b0, win_q[8:0]}) && (bc_q < win_q[18:9]);
              rb = db;
              bc_d = bc_inc;
              if (bc_inc >= 10'(DrainBytes)) begin
                txv = 1'b0; done = 1'b1; ok = 1'b1; ph_d = PH_IDLE; cs_d = 1'b1;
              end
            end
            PH_WTOKEN: begin
              ph_d = PH_WWANT; bc_d = '0; txv = 1'b0; want = 1'b1;
            end
            PH_WDATA: begin
              bc_d = bc_inc;
              if (bc_inc < 10'(BlockBytes)) begin
                ph_d = PH_WWANT; txv = 1'b0; want = 1'b1;
              end else begin
                ph_d = PH_WCRC; bc_d = '0;
              end
            end
            PH_WCRC: begin
              bc_d = bc_inc;
              if (bc_inc >= 10'd2) ph_d = PH_WSTAT;
            end
            PH_WSTAT: begin
              if (db[4:0] != 5'h05) begin
                er_d = ERR_WRITE; txv = 1'b0; done = 1'b1; ph_d = PH_IDLE; cs_d = 1'b1;
              end else begin
                ph_d = PH_WBUSY; bm_d = '0;
              end
            end
            PH_WBUSY: begin
              if (db == 8'hFF) begin
                cmd_d = C13; arg_d = '0; cs_d = 1'b0; bm_d = '0; ph_d = PH_CBUSY;
              end else if (bm_q >= to_write_q) begin
                er_d = ERR_WTIME; txv = 1'b0; done = 1'b1; ph_d = PH_IDLE; cs_d = 1'b1;
              end
            end
            default: begin
              if (db != 8'h00) begin
                er_d = ERR_PROG; txv = 1'b0; done = 1'b1;
              end else begin
                txv = 1'b0; done = 1'b1; ok = 1'b1;
              end
              ph_d = PH_IDLE; cs_d = 1'b1;
            end
          endcase
          if (!txv) txb = 8'h00;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_init_q <= 16'd2000; to_read_q <= 16'd300;
      to_write_q <= 16'd600; to_busy_q <= 16'd300;
      ph_q <= PH_IDLE; bc_q <= '0; pc_q <= '0; el_q <= '0; bm_q <= '0;
      ct_q <= '0; er_q <= ERR_OK; arg_q <= '0; win_q <= '0; cs_q <= 1'b1;
      cmd_q <= C0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INIT_TO: to_init_q <= cfg_data_i;
          REG_READ_TO: to_read_q <= cfg_data_i;
          REG_WRITE_TO: to_write_q <= cfg_data_i;
          REG_BUSY_TO: to_busy_q <= cfg_data_i;
          default: ;
        endcase
      end
      ph_q <= ph_d; bc_q <= bc_d; pc_q <= pc_d; el_q <= el_d; bm_q <= bm_d;
      ct_q <= ct_d; er_q <= er_d; arg_q <= arg_d; win_q <= win_d; cs_q <= cs_d;
      cmd_q <= cmd_d;
      if (go) ov_q <= emit;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      res_q <= '{tx_valid: txv, tx_byte: txb, chip_select_n: cs_d, read_valid: rv,
                 read_byte: rv ? rb : 8'h00, want_host_byte: want, done_res: done,
                 success: ok, error_code: er_d, card_kind: ct_d};
    end
  end
endmodule

### src/sd_spi_mode_host_controller.sv
// SD card host in SPI mode, driven by one event word at a time (init, read,
// write, host write byte, millisecond tick, received SPI byte). Each event
// yields at most one result word. A two-word queue decouples the event input
// from the sequencer, which handles one event per clock; results sit in an
// output register, so one event per cycle is sustained while out_ready_i is
// high. Users write timeout limits (cfg_we_i) only when idle; not enforced.
module sd_spi_mode_host_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] block_number_i,
  input  logic [8:0]  start_offset_i,
  input  logic [9:0]  byte_count_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        chip_select_n_o,
  output logic        read_valid_o,
  output logic [7:0]  read_byte_o,
  output logic        want_host_byte_o,
  output logic        done_res_o,
  output logic        success_o,
  output logic [3:0]  error_code_o,
  output logic [1:0]  card_kind_o,
  output logic        last_o
);
  import sdspi_pkg::*;
  item_t in_item, q_item;
  res_t res;
  logic q_valid, q_ready;

  assign in_item = '{opcode: opcode_i, block_number: block_number_i,
                     start_offset: start_offset_i, byte_count: byte_count_i,
                     data_byte: data_byte_i};

  sdspi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sdspi_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .out_res_o(res)
  );

  assign tx_valid_o = res.tx_valid;
  assign tx_byte_o = res.tx_byte;
  assign chip_select_n_o = res.chip_select_n;
  assign read_valid_o = res.read_valid;
  assign read_byte_o = res.read_byte;
  assign want_host_byte_o = res.want_host_byte;
  assign done_res_o = res.done_res;
  assign success_o = res.success;
  assign error_code_o = res.error_code;
  assign card_kind_o = res.card_kind;
  assign last_o = 1'b1;
endmodule

### src/sdspi_checker.sv
`include "assert_macros.svh"
module sdspi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       tx_valid_o,
  input logic       done_res_o,
  input logic       success_o,
  input logic [3:0] error_code_o,
  input logic       chip_select_n_o
);
  import sdspi_pkg::*;
  `ASSERT_IMPL(a_succ_done, clk_i, rst_ni, out_valid_o && success_o, done_res_o)
  `ASSERT_IMPL(a_done_notx, clk_i, rst_ni, out_valid_o && done_res_o, !tx_valid_o && chip_select_n_o)
  `ASSERT_IMPL(a_ok_code, clk_i, rst_ni, out_valid_o && success_o, error_code_o == ERR_OK)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

bind sd_spi_mode_host_controller sdspi_checker u_chk (.*);
